>>> src/ffha_pkg.sv
// Shared widths, reset values and command codes for the first-fit heap allocator.
// No dependencies; imported by first_fit_heap_allocator.
package ffha_pkg;

   localparam int ADDR_W     = 32;  // byte addresses, base register
   localparam int REQ_W      = 17;  // request byte count
   localparam int LIMIT_W    = 17;  // heap limit register
   localparam int NEED_W     = 18;  // rounded request, can carry past 17 bits
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 56;  // 17 + 32 bits, padded to bytes
   localparam int RSP_DATA_W = 32;

   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h0080_0000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h1_0000;

   localparam logic [NEED_W-1:0] ROUND_ADD = 18'd3;
   localparam int MIN_SPLIT_BYTES = 4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'd1;

   // round a byte count up to a multiple of 4
   function automatic logic [NEED_W-1:0] round_up(input logic [REQ_W-1:0] bytes);
      logic [NEED_W-1:0] sum;
      sum = {1'b0, bytes} + ROUND_ADD;
      return sum & ~ROUND_ADD;
   endfunction

endpackage

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator with merging of free neighbors over headered blocks.
// Depends on ffha_pkg (widths, reset values, codes, rounding).
//
//  channel | direction | beat contents (low bit first)           | accepted when
//  --------+-----------+-------------------------------------------+--------------------------
//  req     | in        | tdata: request_bytes, block_address       | req_tvalid && req_tready
//          |           | tuser: mode (0 allocate, 1 free)          |
//  rsp     | out       | tdata: data_address; tuser: granted       | rsp_tvalid && rsp_tready
//  csr     | in        | index 0 heap_base, 1 heap_limit_bytes     | csr_we
//
// A free is done when its beat is taken and gives no beat. An allocate takes the beat,
// then walks the headers, one read a cycle from the header memory's single read port
// between fit checks, then places or grows and hands the result to the output register.
// Each free run passed as too small adds its fit check, and the header behind it is then
// read again; a split adds the write of the split header. A zero request goes straight to
// the hand-off. Hand-off holds while the output register still waits on rsp_tready.
// Reset is synchronous and clears control state, both registers and the heap top; the
// header memories are not cleared, since only headers that were written are ever read.
// A new beat is taken while a finished result still waits in the output register.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [16:0] request_bytes, [48:17] block_address
   input  logic                  req_tuser,   // [0] mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] data_address
   output logic                  rsp_tuser,   // [0] granted
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_wdata
);

   localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
   localparam int SLOTS  = HEAP_BYTES / 4;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int A_W    = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 2;

   localparam logic [A_W-1:0]    HDR_A       = A_W'(HEADER_BYTES);
   localparam logic [A_W-1:0]    SPLIT_MIN_A = A_W'(HEADER_BYTES + MIN_SPLIT_BYTES);
   localparam logic [A_W-1:0]    HEAP_A      = A_W'(HEAP_BYTES);
   localparam logic [ADDR_W-1:0] HDR_32      = ADDR_W'(HEADER_BYTES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,    // header at off_ff on the read port
      S_MERGE,   // header at nxt_ff on the read port, block at off_ff is free
      S_FIT,     // merged free block complete: take it or move on
      S_SPLIT,   // write the leftover header
      S_GROW,    // extend the heap top
      S_RESULT   // hand result to the output register
   } state_type;

   // header memories: data size and free flag per 4-byte slot
   logic [OFF_W-1:0] size_mem [SLOTS];
   logic             free_mem [SLOTS];

   state_type          state_ff, state_in;
   logic [OFF_W-1:0]   off_ff, off_in;       // offset of the header being walked
   logic [A_W-1:0]     nxt_ff, nxt_in;       // end of the current (merged) block
   logic [OFF_W-1:0]   acc_ff, acc_in;       // merged data size
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [OFF_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_grant_ff, res_grant_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_grant_ff, rsp_grant_in;

   logic [OFF_W-1:0]  rd_size_ff;
   logic              rd_free_ff;
   logic [SLOT_W-1:0] rd_slot;

   logic              size_we;
   logic [SLOT_W-1:0] size_wslot;
   logic [OFF_W-1:0]  size_wdata;
   logic              free_we;
   logic [SLOT_W-1:0] free_wslot;
   logic              free_wdata;

   logic              req_accept;
   logic [REQ_W-1:0]  req_bytes;
   logic [ADDR_W-1:0] req_baddr;
   logic [ADDR_W-1:0] free_off;
   logic              free_hit;

   logic [A_W-1:0]    head_end, merge_end, merge_acc, top_a, need_a, acc_a;
   logic [A_W-1:0]    room, limit_a, cap, split_off, split_size;
   logic              fits, splits;
   logic [ADDR_W-1:0] blk_addr, grow_addr;
   logic              rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_bytes  = req_tdata[REQ_W-1:0];
   assign req_baddr  = req_tdata[REQ_W+ADDR_W-1:REQ_W];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_grant_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // a free names the data address; step back over the header
   assign free_off = req_baddr - base_ff - HDR_32;
   assign free_hit = (req_baddr != '0) && (free_off < ADDR_W'(top_ff));

   assign top_a     = A_W'(top_ff);
   assign need_a    = A_W'(need_ff);
   assign acc_a     = A_W'(acc_ff);
   assign head_end  = A_W'(off_ff) + HDR_A + A_W'(rd_size_ff);
   assign merge_end = nxt_ff + HDR_A + A_W'(rd_size_ff);
   assign merge_acc = acc_a + HDR_A + A_W'(rd_size_ff);
   assign fits      = acc_a >= need_a;
   assign splits    = acc_a >= need_a + SPLIT_MIN_A;
   assign split_off  = A_W'(off_ff) + HDR_A + need_a;
   assign split_size = acc_a - need_a - HDR_A;
   assign room      = top_a + HDR_A + need_a;
   assign limit_a   = A_W'(limit_ff);
   assign cap       = (limit_a < HEAP_A) ? limit_a : HEAP_A;
   assign blk_addr  = base_ff + ADDR_W'(off_ff) + HDR_32;
   assign grow_addr = base_ff + ADDR_W'(top_ff) + HDR_32;

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      nxt_in       = nxt_ff;
      acc_in       = acc_ff;
      need_in      = need_ff;
      top_in       = top_ff;
      res_addr_in  = res_addr_ff;
      res_grant_in = res_grant_ff;
      rd_slot      = off_ff[SLOT_W+1:2];
      size_we      = 1'b0;
      size_wslot   = off_ff[SLOT_W+1:2];
      size_wdata   = acc_ff;
      free_we      = 1'b0;
      free_wslot   = off_ff[SLOT_W+1:2];
      free_wdata   = 1'b0;

      // configuration: the user writes only while idle; the block itself has no guard
      base_in  = base_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAP_BASE:  base_in  = csr_wdata;
            CSR_HEAP_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end

      // output register: drop on take, load from S_RESULT
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_grant_in = rsp_grant_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == MODE_FREE) begin
                  // mark the slot free; merging waits for the next allocate
                  free_we    = free_hit;
                  free_wslot = free_off[SLOT_W+1:2];
                  free_wdata = 1'b1;
               end else if (req_bytes == '0) begin
                  res_addr_in  = '0;
                  res_grant_in = 1'b0;
                  state_in     = S_RESULT;
               end else begin
                  need_in = round_up(req_bytes);
                  off_in  = '0;
                  rd_slot = '0;
                  state_in = (top_ff == '0) ? S_GROW : S_HEAD;
               end
            end
         end

         S_HEAD: begin
            nxt_in = head_end;
            acc_in = rd_size_ff;
            if (rd_free_ff) begin
               if (head_end < top_a) begin
                  rd_slot  = head_end[SLOT_W+1:2];
                  state_in = S_MERGE;
               end else begin
                  state_in = S_FIT;
               end
            end else begin
               // advance past a used block
               off_in = head_end[OFF_W-1:0];
               if (head_end < top_a) begin
                  rd_slot = head_end[SLOT_W+1:2];
               end else begin
                  state_in = S_GROW;
               end
            end
         end

         S_MERGE: begin
            if (rd_free_ff) begin
               acc_in = merge_acc[OFF_W-1:0];
               nxt_in = merge_end;
               if (merge_end < top_a) begin
                  rd_slot = merge_end[SLOT_W+1:2];
               end else begin
                  state_in = S_FIT;
               end
            end else begin
               state_in = S_FIT;
            end
         end

         S_FIT: begin
            size_we = 1'b1;
            if (fits) begin
               free_we      = 1'b1;
               free_wdata   = 1'b0;
               res_addr_in  = blk_addr;
               res_grant_in = 1'b1;
               if (splits) begin
                  size_wdata = need_a[OFF_W-1:0];
                  state_in   = S_SPLIT;
               end else begin
                  state_in = S_RESULT;
               end
            end else begin
               // keep the merged size, walk on
               off_in = nxt_ff[OFF_W-1:0];
               if (nxt_ff < top_a) begin
                  rd_slot  = nxt_ff[SLOT_W+1:2];
                  state_in = S_HEAD;
               end else begin
                  state_in = S_GROW;
               end
            end
         end

         S_SPLIT: begin
            size_we    = 1'b1;
            size_wslot = split_off[SLOT_W+1:2];
            size_wdata = split_size[OFF_W-1:0];
            free_we    = 1'b1;
            free_wslot = split_off[SLOT_W+1:2];
            free_wdata = 1'b1;
            state_in   = S_RESULT;
         end

         S_GROW: begin
            if (room > cap) begin
               res_addr_in  = '0;
               res_grant_in = 1'b0;
            end else begin
               size_we      = 1'b1;
               size_wslot   = top_ff[SLOT_W+1:2];
               size_wdata   = need_a[OFF_W-1:0];
               free_we      = 1'b1;
               free_wslot   = top_ff[SLOT_W+1:2];
               free_wdata   = 1'b0;
               res_addr_in  = grow_addr;
               res_grant_in = 1'b1;
               top_in       = room[OFF_W-1:0];
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            // hold until the output register has room
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_grant_in = res_grant_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // header memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_wslot] <= size_wdata;
      end
      rd_size_ff <= size_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wslot] <= free_wdata;
      end
      rd_free_ff <= free_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         base_ff      <= BASE_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff       <= off_in;
      nxt_ff       <= nxt_in;
      acc_ff       <= acc_in;
      need_ff      <= need_in;
      res_addr_ff  <= res_addr_in;
      res_grant_ff <= res_grant_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_grant_ff <= rsp_grant_in;
   end

`ifndef ASSERT_OFF
   // a new result beat only comes out of the result hand-off state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result beat raised outside result hand-off");

   // the heap top moves only when the heap grows
   a_top_only_grows: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (top_ff != $past(top_ff))) |-> $past(state_ff == S_GROW))
      else $error("heap top changed outside growth");

   // the heap never outgrows the arena
   a_top_in_arena: assert property (@(posedge clock) disable iff (reset)
      A_W'(top_ff) <= HEAP_A)
      else $error("heap top past arena size");

   // a refused allocation carries a zero address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_grant_ff) |-> (rsp_addr_ff == '0))
      else $error("failed allocation with nonzero address");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking bench for first_fit_heap_allocator: directed plan, then random allocate/free
// traffic checked beat by beat against a behavioral first-fit heap kept in the bench.
// Depends on ffha_pkg (widths, reset values, mode and register codes) and the DUT.
`timescale 1ns / 1ps

module testbench
   import ffha_pkg::*;
();

   localparam int HEAP_BYTES      = 65536;
   localparam int HDR_BYTES       = 12;
   localparam int SLOTS           = HEAP_BYTES / 4;
   localparam int LIVE_CAP        = 40;      // force frees at this many live blocks or more
   localparam int STALL_CYCLES    = 600;     // long receiver hold-off
   localparam int QUIET_CYCLES    = 8;       // settle time before a register write
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_CYCLES = 40000;   // longest walk plus longest stall, with margin
   localparam int NUM_DIR         = 22;

   // one header slot: data length and free flag
   typedef struct packed {
      logic               is_free;
      logic [LIMIT_W-1:0] len;
   } hdr_type;

   // one expected result beat
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              granted;
   } grant_type;

   // one row of the directed plan; typed rows carry their expected beat
   typedef struct packed {
      logic              mode;
      logic [REQ_W-1:0]  nbytes;
      logic [ADDR_W-1:0] addr;
      logic              typed;
      logic [ADDR_W-1:0] want_addr;
      logic              want_grant;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [16:0] request_bytes, [48:17] block_address
   logic                  req_tuser;   // [0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] data_address
   logic                  rsp_tuser;   // [0] granted
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0]     csr_wdata;

   // bench copy of the heap: header slots, top and registers
   hdr_type            hdr_mem [SLOTS];
   int                 heap_top;
   logic [ADDR_W-1:0]  cfg_base;
   logic [LIMIT_W-1:0] cfg_limit;

   grant_type grant_q [$];    // expected result beats, oldest first
   int        live_off [$];   // header offsets of blocks handed out and not yet freed
   grant_type rsp_want;

   int send_idle_pct;
   int rsp_idle_pct;
   bit stall_ask;
   int work_items;
   int err_count;
   int quiet;

   first_fit_heap_allocator #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HDR_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Walk the chain from offset 0, merging each free block with the free run behind it,
   // and take the first free block that fits; split off a tail big enough for a header
   // plus 4 bytes. With no fit, grow the top unless that passes the limit.
   function automatic void first_fit_place(input int need, output logic ok, output int at);
      int off;
      int sz;
      int nxt;
      int cap;
      ok  = 1'b0;
      at  = 0;
      off = 0;
      while (off < heap_top) begin
         sz = int'(hdr_mem[off / 4].len);
         if (hdr_mem[off / 4].is_free) begin
            while (1) begin
               nxt = off + HDR_BYTES + sz;
               if (nxt >= heap_top || !hdr_mem[nxt / 4].is_free)
                  break;
               sz += HDR_BYTES + int'(hdr_mem[nxt / 4].len);
            end
            hdr_mem[off / 4].len = LIMIT_W'(sz);
            if (sz >= need) begin
               if (sz >= need + HDR_BYTES + MIN_SPLIT_BYTES) begin
                  hdr_mem[(off + HDR_BYTES + need) / 4] =
                     '{is_free: 1'b1, len: LIMIT_W'(sz - need - HDR_BYTES)};
                  hdr_mem[off / 4].len = LIMIT_W'(need);
               end
               hdr_mem[off / 4].is_free = 1'b0;
               ok = 1'b1;
               at = off;
               return;
            end
         end
         off += HDR_BYTES + sz;
      end
      cap = (int'(cfg_limit) < HEAP_BYTES) ? int'(cfg_limit) : HEAP_BYTES;
      if (heap_top + HDR_BYTES + need > cap)
         return;
      hdr_mem[heap_top / 4] = '{is_free: 1'b0, len: LIMIT_W'(need)};
      at       = heap_top;
      heap_top = heap_top + HDR_BYTES + need;
      ok       = 1'b1;
   endfunction

   // Set the free flag of the addressed slot; drop address zero and anything outside the
   // heap. Returns whether the beat touched the heap at all.
   function automatic bit mark_free(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      if (addr == '0)
         return 1'b0;
      off = addr - cfg_base - ADDR_W'(HDR_BYTES);
      if (off >= ADDR_W'(heap_top))
         return 1'b0;
      hdr_mem[off >> 2].is_free = 1'b1;
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      err_count++;
      if (err_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // Offer one request beat, hold it until accepted, then update the bench heap and queue
   // the expected beat for an allocate. A typed expectation replaces the predicted one.
   task automatic offer_beat(input logic mode, input logic [REQ_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] addr, input logic typed,
                             input grant_type typed_want);
      int        need;
      int        at;
      logic      ok;
      grant_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, addr, nbytes};
      do @(posedge clock); while (!req_tready);

      if (mode == MODE_FREE) begin
         void'(mark_free(addr));
      end else begin
         want = '{addr: '0, granted: 1'b0};
         need = (int'(nbytes) + 3) & ~3;
         if (nbytes != '0) begin
            first_fit_place(need, ok, at);
            if (ok) begin
               want.addr    = cfg_base + ADDR_W'(at + HDR_BYTES);
               want.granted = 1'b1;
               live_off.push_back(at);
            end
         end
         grant_q.push_back(typed ? typed_want : want);
      end
      work_items++;
   endtask

   // Register writes happen only with the block idle: drain results, let a trailing free
   // finish, then write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEAP_BASE)
         cfg_base = data;
      else
         cfg_limit = data[LIMIT_W-1:0];
   endtask

   // Mostly frees of live blocks and small allocates; a few big or oversized requests,
   // zero requests, and noise frees (zero, outside, inside data areas).
   task automatic random_beat();
      int                pick;
      int                k;
      logic [REQ_W-1:0]  nbytes;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      if (live_off.size() != 0 && (live_off.size() >= LIVE_CAP || pick < 45)) begin
         k    = $urandom_range(live_off.size() - 1);
         addr = cfg_base + ADDR_W'(live_off[k] + HDR_BYTES);
         // now and then miss the data address by a few bytes; low bits get dropped
         if ($urandom_range(9) == 0)
            addr = addr + ADDR_W'($urandom_range(3));
         live_off.delete(k);
         offer_beat(MODE_FREE, REQ_W'($urandom), addr, 1'b0, '0);
      end else if (pick < 52) begin
         case ($urandom_range(3))
            0:       addr = '0;
            1:       addr = $urandom;
            2:       addr = cfg_base + ADDR_W'(HDR_BYTES + $urandom_range(heap_top));
            default: addr = cfg_base + ADDR_W'(HDR_BYTES + heap_top + $urandom_range(4096));
         endcase
         offer_beat(MODE_FREE, REQ_W'($urandom), addr, 1'b0, '0);
      end else begin
         pick = $urandom_range(99);
         if (pick < 2)
            nbytes = '0;
         else if (pick < 4)
            nbytes = REQ_W'($urandom_range(17'h1_FFFF));
         else if (pick < 8)
            nbytes = REQ_W'($urandom_range(8192, 1025));
         else if (pick < 20)
            nbytes = REQ_W'($urandom_range(1024, 65));
         else
            nbytes = REQ_W'($urandom_range(64, 1));
         offer_beat(MODE_ALLOC, nbytes, $urandom, 1'b0, '0);
      end
   endtask

   // Run random beats until this phase has offered count beats;
   // optionally ask the receiver for one long hold-off a third of the way in.
   task automatic run_phase(input int count, input bit with_stall);
      int start;
      bit stalled;
      start   = work_items;
      stalled = 1'b0;
      while (work_items - start < count) begin
         if (with_stall && !stalled && work_items - start >= count / 3) begin
            stall_ask = 1'b1;
            stalled   = 1'b1;
         end
         random_beat();
      end
   endtask

   // Receiver: random ready, or a long hold-off on request while the sender keeps going.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_ask) begin
            stall_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            note_mismatch("result beat with none expected", '0, rsp_tdata);
         end else begin
            rsp_want = grant_q.pop_front();
            if (rsp_tdata !== rsp_want.addr)
               note_mismatch("data_address", rsp_want.addr, rsp_tdata);
            if (rsp_tuser !== rsp_want.granted)
               note_mismatch("granted", 32'(rsp_want.granted), 32'(rsp_tuser));
         end
      end
   end

   // Watchdog: count cycles in which no beat moves and no register is written.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WATCHDOG_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_plan [NUM_DIR];
      grant_type   typed_want;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_ALLOC;
      csr_we     = 1'b0;
      csr_index  = CSR_HEAP_BASE;
      csr_wdata  = '0;
      stall_ask  = 1'b0;
      work_items = 0;
      err_count  = 0;
      quiet      = 0;
      foreach (hdr_mem[i])
         hdr_mem[i] = '0;
      heap_top      = 0;
      cfg_base      = BASE_RESET;
      cfg_limit     = LIMIT_RESET;
      send_idle_pct = 7;
      rsp_idle_pct  = 51;

      // Directed plan from an empty heap at reset settings. Offsets in the notes are
      // header offsets; the data address is base + offset + 12.
      dir_plan = '{
         // zero request, oversized requests: fail outright
         '{MODE_ALLOC, 17'd0,       32'd0, 1'b1, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'h1_0000,  32'd0, 1'b1, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'h1_FFFF,  32'd0, 1'b1, 32'd0, 1'b0},
         // free of address zero: dropped
         '{MODE_FREE,  17'd0,       32'd0, 1'b0, 32'd0, 1'b0},
         // first block lands at offset 0
         '{MODE_ALLOC, 17'd1,       32'd0, 1'b1, BASE_RESET + 32'd12, 1'b1},
         // grow: blocks at 16 (8 bytes), 36 (100 bytes), 148 (64 bytes)
         '{MODE_ALLOC, 17'd5,       32'd0, 1'b0, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'd100,     32'd0, 1'b0, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'd64,      32'd0, 1'b0, 32'd0, 1'b0},
         // free 16, and 36 through an unaligned address
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd28, 1'b0, 32'd0, 1'b0},
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd49, 1'b0, 32'd0, 1'b0},
         // frees far outside and exactly at the top: dropped
         '{MODE_FREE,  17'd0,       32'hFFFF_FFFF,        1'b0, 32'd0, 1'b0},
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd236, 1'b0, 32'd0, 1'b0},
         // merge 16 and 36 into 120 bytes, too little left to split
         '{MODE_ALLOC, 17'd108,     32'd0, 1'b0, 32'd0, 1'b0},
         // nothing free: grow at 224
         '{MODE_ALLOC, 17'd8,       32'd0, 1'b0, 32'd0, 1'b0},
         // free 148 and split it, then take the tail as an exact fit
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd160, 1'b0, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'd20,      32'd0, 1'b0, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'd32,      32'd0, 1'b0, 32'd0, 1'b0},
         // free 0 and 16, then merge them and split the result
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd12,  1'b0, 32'd0, 1'b0},
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd28,  1'b0, 32'd0, 1'b0},
         '{MODE_ALLOC, 17'd4,       32'd0, 1'b0, 32'd0, 1'b0},
         // free pointing into a data area rather than at a header
         '{MODE_FREE,  17'd0,       BASE_RESET + 32'd240, 1'b0, 32'd0, 1'b0},
         // growth just past the cap
         '{MODE_ALLOC, 17'd65524,   32'd0, 1'b0, 32'd0, 1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_plan[i]) begin
         typed_want = '{addr: dir_plan[i].want_addr, granted: dir_plan[i].want_grant};
         offer_beat(dir_plan[i].mode, dir_plan[i].nbytes, dir_plan[i].addr,
                    dir_plan[i].typed, typed_want);
      end

      // small cap keeps the chain short while the heap fills and recycles
      write_reg(CSR_HEAP_LIMIT, 32'd4096);
      run_phase(500, 1'b1);

      // swap idling; base near the top of the address space so data addresses wrap,
      // limit zero so only reuse of free blocks can succeed
      send_idle_pct = 51;
      rsp_idle_pct  = 7;
      write_reg(CSR_HEAP_BASE, 32'hFFFF_FFF0);
      write_reg(CSR_HEAP_LIMIT, 32'd0);
      run_phase(250, 1'b0);

      // lowest base, all-ones limit word (caps at the arena size)
      write_reg(CSR_HEAP_BASE, 32'd0);
      write_reg(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      run_phase(450, 1'b0);

      // no idling on either side, random base, limit likely below the top
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_reg(CSR_HEAP_BASE, $urandom);
      write_reg(CSR_HEAP_LIMIT, 32'd8192);
      run_phase(450, 1'b0);

      // drain, then give a trailing free time to settle
      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> first_fit_heap_allocator.f
src/ffha_pkg.sv
src/first_fit_heap_allocator.sv
sim/testbench.sv
